// File: design/salg_pkg.sv
// package for the string art line generator: widths, register indexes,
// quarter-wave sine table, control word types and the microcode rom
// no dependencies
package salg_pkg;

  // figure geometry
  localparam int ANGLE_STEPS         = 360;
  localparam int TABLE_FRACTION_BITS = 14;

  // field widths
  localparam int RADIUS_W   = 12;
  localparam int STEP_W     = 9;
  localparam int FACTOR_W   = 12;
  localparam int CENTER_W   = 11;
  localparam int PALETTE_W  = 8;
  localparam int COORD_W    = 13;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 3;

  // derived widths
  localparam int ANG_W   = $clog2(ANGLE_STEPS);
  localparam int QTAB_N  = ANGLE_STEPS / 2 + 1;
  localparam int QIDX_W  = $clog2(QTAB_N);
  localparam int FOLD_W  = $clog2(2 * ANGLE_STEPS + 1);
  localparam int AS_W    = $clog2(ANGLE_STEPS + 1);
  localparam int DIV_W   = (AS_W > STEP_W) ? AS_W : STEP_W;
  localparam int LIMIT_W = $clog2(ANGLE_STEPS + 2);
  localparam int SEG_W   = $clog2(2 * ANGLE_STEPS + 3);
  localparam int SUM_W   = ((ANG_W > STEP_W) ? ANG_W : STEP_W) + 1;
  localparam int PROD_W  = RADIUS_W + SAMPLE_W;
  localparam int UPC_W   = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_B     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_SET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SIZE = 3'd6;

  // register reset values
  localparam logic [STEP_W-1:0]   ANGLE_STEP_RST = 9'd1;
  localparam logic [FACTOR_W-1:0] FACTOR_SET_RST = 12'd585;

  // quarter-wave sine table, built at elaboration from a q30 taylor series
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned TAYLOR_DIV [1:8] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

  typedef logic [SAMPLE_W-1:0] qtab_t [QTAB_N];

  // magnitude of sin at folded half-step k, 0 <= k <= ANGLE_STEPS/2
  function automatic logic [SAMPLE_W-1:0] quarter_sample(int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum_pos;
    longint unsigned sum_neg;
    longint unsigned r;
    x       = (PI_Q30 * longint'(k)) / ANGLE_STEPS;
    term    = x;
    sum_pos = x;
    sum_neg = 64'd0;
    for (int n = 1; n <= 8; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum_neg = sum_neg + term;
      end else begin
        sum_pos = sum_pos + term;
      end
    end
    r = (sum_pos > sum_neg) ? sum_pos - sum_neg : 64'd0;
    r = (r + (64'd1 << (29 - TABLE_FRACTION_BITS))) >> (30 - TABLE_FRACTION_BITS);
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k < QTAB_N; k++) begin
      t[k] = quarter_sample(k);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // sequencer operations
  typedef enum logic [3:0] {
    SQ_NEXT,
    SQ_JUMP,
    SQ_DISPATCH,
    SQ_EMIT,
    SQ_INIT,
    SQ_TEST_B,
    SQ_WAIT_REM,
    SQ_QUOT,
    SQ_WAIT_QUOT
  } seq_op_t;

  // destination of a finished coordinate
  typedef enum logic [1:0] {
    DST_P1X,
    DST_P1Y,
    DST_P2X,
    DST_P2Y
  } point_dst_t;

  // coordinate datapath controls, one field group per stage
  typedef struct packed {
    logic       idx_en;
    logic [1:0] idx_fac;
    logic       idx_cos;
    logic       look_en;
    logic       mul_en;
    logic       mul_rb;
    logic       wr_cy;
  } dp_ctrl_t;

  // one microcode word
  typedef struct packed {
    dp_ctrl_t         dp;
    logic             wr_en;
    point_dst_t       wr_dst;
    seq_op_t          seq;
    logic [UPC_W-1:0] target;
  } ucw_t;

  // program entry points
  localparam logic [UPC_W-1:0] UA_IDLE   = 5'd0;
  localparam logic [UPC_W-1:0] UA_SEG0   = 5'd1;
  localparam logic [UPC_W-1:0] UA_SEG1   = 5'd7;
  localparam logic [UPC_W-1:0] UA_START  = 5'd13;
  localparam logic [UPC_W-1:0] UA_TEST_B = 5'd14;
  localparam logic [UPC_W-1:0] UA_QUOT   = 5'd16;

  // microcode rom
  function automatic ucw_t ucode(logic [UPC_W-1:0] a);
    ucw_t w;
    w        = '0;
    w.seq    = SQ_NEXT;
    w.target = UA_IDLE;
    unique case (a)
      UA_IDLE: begin
        w.seq = SQ_DISPATCH;
      end
      // first segment: new point one, held point two
      UA_SEG0: begin
        w.dp.idx_en  = 1'b1;
        w.dp.idx_fac = 2'd0;
      end
      UA_SEG0 + 5'd1: begin
        w.dp.idx_en  = 1'b1;
        w.dp.idx_fac = 2'd1;
        w.dp.idx_cos = 1'b1;
        w.dp.look_en = 1'b1;
      end
      UA_SEG0 + 5'd2: begin
        w.dp.look_en = 1'b1;
        w.dp.mul_en  = 1'b1;
      end
      UA_SEG0 + 5'd3: begin
        w.dp.mul_en = 1'b1;
        w.dp.mul_rb = 1'b1;
        w.wr_en     = 1'b1;
        w.wr_dst    = DST_P1X;
      end
      UA_SEG0 + 5'd4: begin
        w.dp.wr_cy = 1'b1;
        w.wr_en    = 1'b1;
        w.wr_dst   = DST_P1Y;
      end
      UA_SEG0 + 5'd5: begin
        w.seq = SQ_EMIT;
      end
      // second segment: point one to a new point two
      UA_SEG1: begin
        w.dp.idx_en  = 1'b1;
        w.dp.idx_fac = 2'd2;
      end
      UA_SEG1 + 5'd1: begin
        w.dp.idx_en  = 1'b1;
        w.dp.idx_fac = 2'd3;
        w.dp.idx_cos = 1'b1;
        w.dp.look_en = 1'b1;
      end
      UA_SEG1 + 5'd2: begin
        w.dp.look_en = 1'b1;
        w.dp.mul_en  = 1'b1;
        w.dp.mul_rb  = 1'b1;
      end
      UA_SEG1 + 5'd3: begin
        w.dp.mul_en = 1'b1;
        w.wr_en     = 1'b1;
        w.wr_dst    = DST_P2X;
      end
      UA_SEG1 + 5'd4: begin
        w.dp.wr_cy = 1'b1;
        w.wr_en    = 1'b1;
        w.wr_dst   = DST_P2Y;
      end
      UA_SEG1 + 5'd5: begin
        w.seq = SQ_EMIT;
      end
      // start: euclid on the shared divider, then the loop limit
      UA_START: begin
        w.seq = SQ_INIT;
      end
      UA_TEST_B: begin
        w.seq    = SQ_TEST_B;
        w.target = UA_QUOT;
      end
      UA_TEST_B + 5'd1: begin
        w.seq    = SQ_WAIT_REM;
        w.target = UA_TEST_B;
      end
      UA_QUOT: begin
        w.seq = SQ_QUOT;
      end
      UA_QUOT + 5'd1: begin
        w.seq    = SQ_WAIT_QUOT;
        w.target = UA_IDLE;
      end
      default: begin
        w.seq    = SQ_JUMP;
        w.target = UA_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: design/string_art_line_generator_core.sv
// top level of the string art line generator: microcode sequencer, state,
// configuration registers and output register; uses salg_pkg, salg_coord, salg_div
//
// usage
// - input channel (in_valid / in_stall, field in_start_req): start_req = 1
//   begins a figure and gives no result; start_req = 0 asks for the next
//   segment and gives one result while a figure is running, none when idle
// - result channel (out_valid / out_stall): two endpoints, colour, mono, last;
//   last marks the final segment, after which segment requests give nothing
// - configuration: cfg_we writes cfg_wdata into register cfg_index; write
//   only while no transaction is in progress
// - one transaction at a time; in_stall is high from acceptance until the
//   sequencer is back at its idle step
// - segment request: the result comes from the four-stage coordinate
//   datapath running two coordinates through the microcode
// - start request: in_stall stays high through the euclid remainder steps
//   and the final quotient; each division is an issue step, then nine bit
//   steps on the shared bit-serial divider and one step to collect the result
// - the output register holds a result until taken; a later result waits in
//   the emit step while the receiver stalls
// - reset (rst_n low, synchronous) clears the figure state and restores
//   register defaults; the sine table is constant and needs no fill
module string_art_line_generator_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_we,
  input  logic [salg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [salg_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_start_req,
  // segment channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [salg_pkg::COORD_W-1:0]   out_x_from,
  output logic signed [salg_pkg::COORD_W-1:0]   out_y_from,
  output logic signed [salg_pkg::COORD_W-1:0]   out_x_to,
  output logic signed [salg_pkg::COORD_W-1:0]   out_y_to,
  output logic [salg_pkg::PALETTE_W-1:0]        out_colour_index,
  output logic                                  out_mono,
  output logic                                  out_last
);
  import salg_pkg::*;

  // configuration registers
  logic signed [RADIUS_W-1:0] radius_a_r, radius_a_nxt;
  logic signed [RADIUS_W-1:0] radius_b_r, radius_b_nxt;
  logic [STEP_W-1:0]          angle_step_r, angle_step_nxt;
  logic [FACTOR_W-1:0]        factor_set_r, factor_set_nxt;
  logic [CENTER_W-1:0]        center_x_r, center_x_nxt;
  logic [CENTER_W-1:0]        center_y_r, center_y_nxt;
  logic [PALETTE_W-1:0]       palette_r, palette_nxt;

  // sequencer and figure state
  logic [UPC_W-1:0]   upc_r, upc_nxt;
  logic [ANG_W-1:0]   angle_r, angle_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [SEG_W-1:0]   seg_r, seg_nxt;
  logic               phase_r, phase_nxt;
  logic               active_r, active_nxt;
  logic [PALETTE_W-1:0] colour_r, colour_nxt;
  logic [COORD_W-1:0] p1x_r, p1x_nxt, p1y_r, p1y_nxt;
  logic [COORD_W-1:0] p2x_r, p2x_nxt, p2y_r, p2y_nxt;
  logic [DIV_W-1:0]   a_r, a_nxt, b_r, b_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0]   ox_from_r, ox_from_nxt, oy_from_r, oy_from_nxt;
  logic [COORD_W-1:0]   ox_to_r, ox_to_nxt, oy_to_r, oy_to_nxt;
  logic [PALETTE_W-1:0] ocol_r, ocol_nxt;
  logic                 omono_r, omono_nxt;
  logic                 olast_r, olast_nxt;

  // datapath links
  ucw_t               uw;
  logic [COORD_W-1:0] coord;
  logic               div_go;
  logic [DIV_W-1:0]   div_dividend;
  logic [DIV_W-1:0]   div_divisor;
  logic               div_busy;
  logic [DIV_W-1:0]   div_quo;
  logic [DIV_W-1:0]   div_rem;
  logic               mono;
  logic [PALETTE_W-1:0] colour_adv;
  logic [SEG_W-1:0]   seg_inc;
  logic               is_last;
  logic [SUM_W-1:0]   angle_sum;

  assign uw = ucode(upc_r);

  salg_coord u_coord (
    .clk        (clk),
    .dp         (uw.dp),
    .angle      (angle_r),
    .factor_set (factor_set_r),
    .radius_a   (radius_a_r),
    .radius_b   (radius_b_r),
    .center_x   (center_x_r),
    .center_y   (center_y_r),
    .coord      (coord)
  );

  salg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // shared helpers: palette mode, colour rotation, segment count, angle step
  always_comb begin
    mono = (palette_r <= PALETTE_W'(2));
    if ((PALETTE_W + 1)'(colour_r) + (PALETTE_W + 1)'(1) >= (PALETTE_W + 1)'(palette_r)) begin
      colour_adv = '0;
    end else begin
      colour_adv = colour_r + PALETTE_W'(1);
    end
    seg_inc   = seg_r + SEG_W'(1);
    is_last   = (seg_inc >= SEG_W'({limit_r, 1'b0}));
    angle_sum = SUM_W'(angle_r) + SUM_W'(angle_step_r);
    if (angle_sum >= SUM_W'(2 * ANGLE_STEPS)) begin
      angle_sum = angle_sum - SUM_W'(2 * ANGLE_STEPS);
    end else if (angle_sum >= SUM_W'(ANGLE_STEPS)) begin
      angle_sum = angle_sum - SUM_W'(ANGLE_STEPS);
    end
  end

  // sequencer, figure state and configuration writes
  always_comb begin
    radius_a_nxt   = radius_a_r;
    radius_b_nxt   = radius_b_r;
    angle_step_nxt = angle_step_r;
    factor_set_nxt = factor_set_r;
    center_x_nxt   = center_x_r;
    center_y_nxt   = center_y_r;
    palette_nxt    = palette_r;
    upc_nxt        = upc_r;
    angle_nxt      = angle_r;
    limit_nxt      = limit_r;
    seg_nxt        = seg_r;
    phase_nxt      = phase_r;
    active_nxt     = active_r;
    colour_nxt     = colour_r;
    p1x_nxt        = p1x_r;
    p1y_nxt        = p1y_r;
    p2x_nxt        = p2x_r;
    p2y_nxt        = p2y_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    out_valid_nxt  = out_valid_r;
    ox_from_nxt    = ox_from_r;
    oy_from_nxt    = oy_from_r;
    ox_to_nxt      = ox_to_r;
    oy_to_nxt      = oy_to_r;
    ocol_nxt       = ocol_r;
    omono_nxt      = omono_r;
    olast_nxt      = olast_r;
    div_go         = 1'b0;
    div_dividend   = a_r;
    div_divisor    = b_r;

    // configuration write
    if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS_A:     radius_a_nxt   = cfg_wdata[RADIUS_W-1:0];
        REG_RADIUS_B:     radius_b_nxt   = cfg_wdata[RADIUS_W-1:0];
        REG_ANGLE_STEP:   angle_step_nxt = cfg_wdata[STEP_W-1:0];
        REG_FACTOR_SET:   factor_set_nxt = cfg_wdata[FACTOR_W-1:0];
        REG_CENTER_X:     center_x_nxt   = cfg_wdata[CENTER_W-1:0];
        REG_CENTER_Y:     center_y_nxt   = cfg_wdata[CENTER_W-1:0];
        REG_PALETTE_SIZE: palette_nxt    = cfg_wdata[PALETTE_W-1:0];
        default: ;
      endcase
    end

    // result taken by the receiver
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // coordinate write-back
    if (uw.wr_en) begin
      unique case (uw.wr_dst)
        DST_P1X: p1x_nxt = coord;
        DST_P1Y: p1y_nxt = coord;
        DST_P2X: p2x_nxt = coord;
        DST_P2Y: p2y_nxt = coord;
      endcase
    end

    unique case (uw.seq)
      SQ_NEXT: begin
        upc_nxt = upc_r + UPC_W'(1);
      end
      SQ_JUMP: begin
        upc_nxt = uw.target;
      end
      // take a transaction and pick the routine
      SQ_DISPATCH: begin
        if (in_valid) begin
          priority if (in_start_req) begin
            upc_nxt = UA_START;
          end else if (active_r) begin
            upc_nxt = phase_r ? UA_SEG1 : UA_SEG0;
          end else begin
            upc_nxt = UA_IDLE;
          end
        end
      end
      // hand the segment to the output register once it is free
      SQ_EMIT: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          ox_from_nxt   = p1x_r;
          oy_from_nxt   = p1y_r;
          ox_to_nxt     = p2x_r;
          oy_to_nxt     = p2y_r;
          omono_nxt     = mono;
          ocol_nxt      = mono ? '0 : colour_r;
          olast_nxt     = is_last;
          if (!mono) begin
            colour_nxt = colour_adv;
          end
          seg_nxt = seg_inc;
          if (is_last) begin
            active_nxt = 1'b0;
          end
          if (phase_r) begin
            angle_nxt = angle_sum[ANG_W-1:0];
          end
          phase_nxt = !phase_r;
          upc_nxt   = uw.target;
        end
      end
      // new figure: clear the walk and seed euclid
      SQ_INIT: begin
        angle_nxt  = '0;
        seg_nxt    = '0;
        phase_nxt  = 1'b0;
        active_nxt = 1'b1;
        p2x_nxt    = COORD_W'(center_x_r);
        p2y_nxt    = COORD_W'(center_y_r) + COORD_W'(radius_a_r);
        a_nxt      = DIV_W'(ANGLE_STEPS);
        b_nxt      = DIV_W'(angle_step_r);
        if (!mono) begin
          colour_nxt = colour_adv;
        end
        upc_nxt = upc_r + UPC_W'(1);
      end
      SQ_TEST_B: begin
        if (b_r == '0) begin
          upc_nxt = uw.target;
        end else begin
          div_go  = 1'b1;
          upc_nxt = upc_r + UPC_W'(1);
        end
      end
      SQ_WAIT_REM: begin
        if (!div_busy) begin
          a_nxt   = b_r;
          b_nxt   = div_rem;
          upc_nxt = uw.target;
        end
      end
      SQ_QUOT: begin
        div_go       = 1'b1;
        div_dividend = DIV_W'(ANGLE_STEPS);
        div_divisor  = a_r;
        upc_nxt      = upc_r + UPC_W'(1);
      end
      SQ_WAIT_QUOT: begin
        if (!div_busy) begin
          limit_nxt = LIMIT_W'(div_quo) + LIMIT_W'(1);
          upc_nxt   = uw.target;
        end
      end
      default: begin
        upc_nxt = UA_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_a_r   <= '0;
      radius_b_r   <= '0;
      angle_step_r <= ANGLE_STEP_RST;
      factor_set_r <= FACTOR_SET_RST;
      center_x_r   <= '0;
      center_y_r   <= '0;
      palette_r    <= '0;
      upc_r        <= UA_IDLE;
      angle_r      <= '0;
      limit_r      <= '0;
      seg_r        <= '0;
      phase_r      <= 1'b0;
      active_r     <= 1'b0;
      colour_r     <= '0;
      p1x_r        <= '0;
      p1y_r        <= '0;
      p2x_r        <= '0;
      p2y_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      radius_a_r   <= radius_a_nxt;
      radius_b_r   <= radius_b_nxt;
      angle_step_r <= angle_step_nxt;
      factor_set_r <= factor_set_nxt;
      center_x_r   <= center_x_nxt;
      center_y_r   <= center_y_nxt;
      palette_r    <= palette_nxt;
      upc_r        <= upc_nxt;
      angle_r      <= angle_nxt;
      limit_r      <= limit_nxt;
      seg_r        <= seg_nxt;
      phase_r      <= phase_nxt;
      active_r     <= active_nxt;
      colour_r     <= colour_nxt;
      p1x_r        <= p1x_nxt;
      p1y_r        <= p1y_nxt;
      p2x_r        <= p2x_nxt;
      p2y_r        <= p2y_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    ox_from_r <= ox_from_nxt;
    oy_from_r <= oy_from_nxt;
    ox_to_r   <= ox_to_nxt;
    oy_to_r   <= oy_to_nxt;
    ocol_r    <= ocol_nxt;
    omono_r   <= omono_nxt;
    olast_r   <= olast_nxt;
  end

  // ports
  assign in_stall         = (upc_r != UA_IDLE);
  assign out_valid        = out_valid_r;
  assign out_x_from       = ox_from_r;
  assign out_y_from       = oy_from_r;
  assign out_x_to         = ox_to_r;
  assign out_y_to         = oy_to_r;
  assign out_colour_index = ocol_r;
  assign out_mono         = omono_r;
  assign out_last         = olast_r;

endmodule

// File: design/salg_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on salg_pkg for the operand width
module salg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [salg_pkg::DIV_W-1:0] dividend,
  input  logic [salg_pkg::DIV_W-1:0] divisor,
  output logic                       busy,
  output logic [salg_pkg::DIV_W-1:0] quotient,
  output logic [salg_pkg::DIV_W-1:0] remainder
);
  import salg_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic               busy_r, busy_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_W-1:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0]   quo_r, quo_nxt;
  logic [DIV_W-1:0]   den_r, den_nxt;
  logic [DIV_W:0]     shifted;
  logic               fits;

  // one shift and trial subtract per cycle
  always_comb begin
    shifted  = {rem_r, quo_r[DIV_W-1]};
    fits     = (shifted >= {1'b0, den_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DIV_W'(shifted - {1'b0, den_r}) : shifted[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: design/salg_coord.sv
// coordinate datapath: table index, sine lookup, radius multiply, centre add
// the index, lookup and multiply stages are each enabled by their own field of the microcode word; uses salg_pkg
module salg_coord (
  input  logic                              clk,
  input  salg_pkg::dp_ctrl_t                dp,
  input  logic [salg_pkg::ANG_W-1:0]        angle,
  input  logic [salg_pkg::FACTOR_W-1:0]     factor_set,
  input  logic signed [salg_pkg::RADIUS_W-1:0] radius_a,
  input  logic signed [salg_pkg::RADIUS_W-1:0] radius_b,
  input  logic [salg_pkg::CENTER_W-1:0]     center_x,
  input  logic [salg_pkg::CENTER_W-1:0]     center_y,
  output logic [salg_pkg::COORD_W-1:0]      coord
);
  import salg_pkg::*;

  localparam int AP_W = ANG_W + 3;

  logic [2:0]                  raw;
  logic [2:0]                  mag;
  logic [AP_W-1:0]             ap;
  logic [AP_W-1:0]             ap_red;
  logic [ANG_W-1:0]            sin_idx;
  logic [ANG_W:0]              cos_sum;
  logic [ANG_W-1:0]            idx_r, idx_nxt;
  logic [FOLD_W-1:0]           k0, k1, k2;
  logic                        half_neg;
  logic [SAMPLE_W-1:0]         qmag;
  logic signed [SAMPLE_W-1:0]  samp_r, samp_nxt;
  logic signed [RADIUS_W-1:0]  rad;
  logic signed [PROD_W-1:0]    prod_r, prod_nxt;
  logic signed [PROD_W-1:0]    biased;
  logic signed [PROD_W-1:0]    scaled;
  logic [CENTER_W-1:0]         centre;

  // index stage: (angle * f) mod steps, negative factors mirrored
  always_comb begin
    unique case (dp.idx_fac)
      2'd0:    raw = factor_set[2:0];
      2'd1:    raw = factor_set[5:3];
      2'd2:    raw = factor_set[8:6];
      default: raw = factor_set[11:9];
    endcase
    mag = raw[2] ? 3'(4'd8 - {1'b0, raw}) : raw;
    ap  = AP_W'(angle) * AP_W'(mag);
    priority if (ap >= AP_W'(3 * ANGLE_STEPS)) begin
      ap_red = ap - AP_W'(3 * ANGLE_STEPS);
    end else if (ap >= AP_W'(2 * ANGLE_STEPS)) begin
      ap_red = ap - AP_W'(2 * ANGLE_STEPS);
    end else if (ap >= AP_W'(ANGLE_STEPS)) begin
      ap_red = ap - AP_W'(ANGLE_STEPS);
    end else begin
      ap_red = ap;
    end
    sin_idx = ap_red[ANG_W-1:0];
    if (raw[2] && (sin_idx != '0)) begin
      sin_idx = ANG_W'(ANGLE_STEPS) - sin_idx;
    end
    // cosine reads a quarter turn further on
    cos_sum = (ANG_W + 1)'(sin_idx) + (ANG_W + 1)'(ANGLE_STEPS / 4);
    if (cos_sum >= (ANG_W + 1)'(ANGLE_STEPS)) begin
      cos_sum = cos_sum - (ANG_W + 1)'(ANGLE_STEPS);
    end
    idx_nxt = dp.idx_en ? (dp.idx_cos ? cos_sum[ANG_W-1:0] : sin_idx) : idx_r;
  end

  // lookup stage: fold the index onto the quarter-wave table
  always_comb begin
    k0       = FOLD_W'({idx_r, 1'b0});
    half_neg = (k0 > FOLD_W'(ANGLE_STEPS));
    k1       = half_neg ? FOLD_W'(2 * ANGLE_STEPS) - k0 : k0;
    if ({k1, 1'b0} > (FOLD_W + 1)'(ANGLE_STEPS)) begin
      k2 = FOLD_W'(ANGLE_STEPS) - k1;
    end else begin
      k2 = k1;
    end
    qmag     = QTAB[k2[QIDX_W-1:0]];
    samp_nxt = dp.look_en ? (half_neg ? -$signed(qmag) : $signed(qmag)) : samp_r;
  end

  // multiply stage
  always_comb begin
    rad      = dp.mul_rb ? radius_b : radius_a;
    prod_nxt = dp.mul_en ? rad * samp_r : prod_r;
  end

  // write stage: scale back truncating toward zero, add the centre
  always_comb begin
    biased = prod_r + (prod_r[PROD_W-1] ? PROD_W'((1 << TABLE_FRACTION_BITS) - 1)
                                        : PROD_W'(0));
    scaled = biased >>> TABLE_FRACTION_BITS;
    centre = dp.wr_cy ? center_y : center_x;
    coord  = COORD_W'(centre) + scaled[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    samp_r <= samp_nxt;
    prod_r <= prod_nxt;
  end

endmodule

// File: verif/tb_string_art_line_generator_core.sv
// testbench for string_art_line_generator_core: directed and random figures,
// a self-contained segment predictor in a scoreboard class, random idling on both channels
// depends on salg_pkg and the core only
typedef struct packed {
  logic [salg_pkg::COORD_W-1:0]   x_from;
  logic [salg_pkg::COORD_W-1:0]   y_from;
  logic [salg_pkg::COORD_W-1:0]   x_to;
  logic [salg_pkg::COORD_W-1:0]   y_to;
  logic [salg_pkg::PALETTE_W-1:0] colour;
  logic                           mono;
  logic                           last;
} segment_t;

// greatest common divisor of the full turn and an angle step
function automatic int unsigned steps_gcd(int unsigned b);
  int unsigned a;
  int unsigned t;
  a = salg_pkg::ANGLE_STEPS;
  while (b > 0) begin
    t = a % b;
    a = b;
    b = t;
  end
  return a;
endfunction

class segment_scoreboard;
  int sine [salg_pkg::ANGLE_STEPS];

  // register copies
  logic [11:0] ra;
  logic [11:0] rb;
  logic [8:0]  step;
  logic [11:0] factors;
  logic [10:0] cx;
  logic [10:0] cy;
  logic [7:0]  pal;

  // figure state
  int unsigned angle;
  int unsigned limit;
  int unsigned count;
  bit          phase;
  bit          active;
  int          p1x, p1y, p2x, p2y;
  int unsigned colour_state;

  segment_t segments_due [$];
  int       errors;

  function new();
    for (int i = 0; i < salg_pkg::ANGLE_STEPS; i++) begin
      sine[i] = sine_sample(i);
    end
    ra = '0;
    rb = '0;
    step = 9'd1;
    factors = 12'd585;
    cx = '0;
    cy = '0;
    pal = '0;
    angle = 0;
    limit = 0;
    count = 0;
    phase = 0;
    active = 0;
    p1x = 0;
    p1y = 0;
    p2x = 0;
    p2y = 0;
    colour_state = 0;
    errors = 0;
  endfunction

  // rounded sine sample in q2.14 from a q30 taylor series
  function int sine_sample(int unsigned i);
    longint unsigned x, term, sum_pos, sum_neg, r;
    int unsigned k;
    int unsigned n;
    bit neg;
    k = 2 * i;
    neg = 0;
    if (k > salg_pkg::ANGLE_STEPS) begin
      neg = 1;
      k = 2 * salg_pkg::ANGLE_STEPS - k;
    end
    if (2 * k > salg_pkg::ANGLE_STEPS) k = salg_pkg::ANGLE_STEPS - k;
    x = (64'd3373259426 * k) / salg_pkg::ANGLE_STEPS;
    term = x;
    sum_pos = x;
    sum_neg = 0;
    for (n = 1; n <= 8; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum_neg += term;
      else sum_pos += term;
    end
    r = (sum_pos > sum_neg) ? sum_pos - sum_neg : 64'd0;
    r = (r + (64'd1 << (29 - salg_pkg::TABLE_FRACTION_BITS)))
        >> (30 - salg_pkg::TABLE_FRACTION_BITS);
    return neg ? -int'(r) : int'(r);
  endfunction

  // angle times one of the packed multipliers, kept non-negative
  function int unsigned angle_index(int which);
    logic [2:0]  raw;
    int unsigned mag;
    int unsigned r;
    raw = factors[3 * which +: 3];
    mag = (raw < 4) ? raw : 8 - raw;
    r = ((angle % salg_pkg::ANGLE_STEPS) * mag) % salg_pkg::ANGLE_STEPS;
    if (raw >= 4 && r != 0) r = salg_pkg::ANGLE_STEPS - r;
    return r;
  endfunction

  function int cosine(int unsigned i);
    return sine[(i + salg_pkg::ANGLE_STEPS / 4) % salg_pkg::ANGLE_STEPS];
  endfunction

  // centre plus radius times sample, product truncated toward zero
  function int coord(int centre, logic [11:0] radius, int sample);
    int p;
    p = int'($signed(radius)) * sample;
    if (p < 0) return centre - ((-p) >> salg_pkg::TABLE_FRACTION_BITS);
    return centre + (p >> salg_pkg::TABLE_FRACTION_BITS);
  endfunction

  function void advance_colour();
    if (colour_state + 1 >= pal) colour_state = 0;
    else colour_state = (colour_state + 1) & 8'hFF;
  endfunction

  function void write_reg(logic [2:0] idx, logic [11:0] data);
    case (idx)
      salg_pkg::REG_RADIUS_A:     ra = data;
      salg_pkg::REG_RADIUS_B:     rb = data;
      salg_pkg::REG_ANGLE_STEP:   step = data[8:0];
      salg_pkg::REG_FACTOR_SET:   factors = data;
      salg_pkg::REG_CENTER_X:     cx = data[10:0];
      salg_pkg::REG_CENTER_Y:     cy = data[10:0];
      salg_pkg::REG_PALETTE_SIZE: pal = data[7:0];
      default: ;
    endcase
  endfunction

  // one accepted request transaction, queues the segment it yields
  function void note_request(bit start_req);
    segment_t s;
    if (start_req) begin
      limit = 1 + salg_pkg::ANGLE_STEPS / steps_gcd(step);
      angle = 0;
      count = 0;
      phase = 0;
      p2x = cx;
      p2y = int'(cy) + int'($signed(ra));
      active = 1;
      if (pal > 2) advance_colour();
      return;
    end
    if (!active) return;
    if (!phase) begin
      p1x = coord(cx, ra, sine[angle_index(0)]);
      p1y = coord(cy, rb, cosine(angle_index(1)));
      phase = 1;
    end else begin
      p2x = coord(cx, rb, sine[angle_index(2)]);
      p2y = coord(cy, ra, cosine(angle_index(3)));
      angle = (angle + step) % salg_pkg::ANGLE_STEPS;
      phase = 0;
    end
    s.x_from = p1x[12:0];
    s.y_from = p1y[12:0];
    s.x_to = p2x[12:0];
    s.y_to = p2y[12:0];
    s.mono = (pal <= 2);
    s.colour = '0;
    if (!s.mono) begin
      s.colour = colour_state[7:0];
      advance_colour();
    end
    count++;
    s.last = (count >= 2 * limit);
    if (s.last) active = 0;
    segments_due.push_back(s);
  endfunction

  // one accepted segment transaction against the oldest one due
  function void check_segment(segment_t got);
    segment_t want;
    bit bad;
    if (segments_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("segment with nothing due: %0d,%0d -> %0d,%0d",
                 $signed(got.x_from), $signed(got.y_from),
                 $signed(got.x_to), $signed(got.y_to));
      return;
    end
    want = segments_due.pop_front();
    bad = (got.x_from !== want.x_from) || (got.y_from !== want.y_from) ||
          (got.x_to !== want.x_to) || (got.y_to !== want.y_to) ||
          (got.colour !== want.colour) || (got.mono !== want.mono) ||
          (got.last !== want.last);
    if (bad) begin
      errors++;
      if (errors <= 10) begin
        $display("segment mismatch, want %0d,%0d -> %0d,%0d colour %0d mono %0b last %0b",
                 $signed(want.x_from), $signed(want.y_from), $signed(want.x_to),
                 $signed(want.y_to), want.colour, want.mono, want.last);
        $display("                  got  %0d,%0d -> %0d,%0d colour %0d mono %0b last %0b",
                 $signed(got.x_from), $signed(got.y_from), $signed(got.x_to),
                 $signed(got.y_to), got.colour, got.mono, got.last);
      end
    end
  endfunction

  function int pending();
    return segments_due.size();
  endfunction
endclass

module tb_string_art_line_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import salg_pkg::*;

  localparam int          CYCLE_LIMIT  = 1_500_000;
  localparam int          START_CYCLES = 160;
  localparam int          ITEM_TARGET  = 1200;
  localparam logic [2:0]  REG_NONE     = 3'd7;
  localparam int unsigned SHORT_STEPS [18] =
    '{0, 180, 120, 90, 72, 60, 45, 40, 36, 30, 24, 20, 18, 15, 12, 10, 400, 440};

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic in_start_req;
  logic out_valid;
  logic out_stall;
  logic signed [COORD_W-1:0] out_x_from;
  logic signed [COORD_W-1:0] out_y_from;
  logic signed [COORD_W-1:0] out_x_to;
  logic signed [COORD_W-1:0] out_y_to;
  logic [PALETTE_W-1:0] out_colour_index;
  logic out_mono;
  logic out_last;

  segment_scoreboard sb;
  segment_t          seen;
  int                cycles;
  bit                calm;
  int unsigned       step_now;
  int                counted;

  string_art_line_generator_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_req    (in_start_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x_from      (out_x_from),
    .out_y_from      (out_y_from),
    .out_x_to        (out_x_to),
    .out_y_to        (out_y_to),
    .out_colour_index(out_colour_index),
    .out_mono        (out_mono),
    .out_last        (out_last)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // observe every transaction and config write at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen = '{out_x_from, out_y_from, out_x_to, out_y_to,
                 out_colour_index, out_mono, out_last};
        sb.check_segment(seen);
      end
      if (in_valid && !in_stall) sb.note_request(in_start_req);
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
    end
  end

  // gap length, mostly short and a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 9);
    if (calm || r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // receiver stalls
  initial begin
    out_stall = 1'b0;
    forever begin
      int on;
      on = idle_len();
      if (on > 0) begin
        out_stall <= 1'b1;
        repeat (on) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  end

  // random write data for one register index
  function automatic logic [11:0] reg_value(logic [2:0] idx);
    int unsigned pick;
    logic [8:0] st;
    logic [7:0] pl;
    pick = $urandom_range(0, 5);
    case (idx)
      REG_RADIUS_A, REG_RADIUS_B: begin
        case (pick)
          0: return 12'h7FF;
          1: return 12'h801;
          2: return 12'h800;
          3: return 12'h000;
          default: return 12'($urandom);
        endcase
      end
      REG_ANGLE_STEP: begin
        if (pick == 0) st = 9'($urandom_range(0, 511));
        else st = 9'(SHORT_STEPS[$urandom_range(0, 17)]);
        return {3'($urandom), st};
      end
      REG_FACTOR_SET: begin
        case (pick)
          0: return 12'h924;
          1: return 12'hFFF;
          2: return 12'h249;
          3: return 12'h000;
          default: return 12'($urandom);
        endcase
      end
      REG_CENTER_X, REG_CENTER_Y: begin
        case (pick)
          0: return 12'h7FF;
          1: return 12'h800;
          default: return 12'($urandom);
        endcase
      end
      REG_PALETTE_SIZE: begin
        case (pick)
          0: pl = 8'd0;
          1: pl = 8'd1;
          2: pl = 8'd2;
          3: pl = 8'd3;
          4: pl = 8'd255;
          default: pl = 8'($urandom);
        endcase
        return {4'($urandom), pl};
      end
      default: return 12'($urandom);
    endcase
  endfunction

  // one config write; cfg_we stays high for a following write
  task automatic put_reg(logic [2:0] idx, logic [11:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_ANGLE_STEP) step_now = data[8:0];
    @(posedge clk);
  endtask

  task automatic put_all(logic [11:0] a, logic [11:0] b, logic [11:0] st,
                         logic [11:0] fac, logic [11:0] x, logic [11:0] y,
                         logic [11:0] pl);
    put_reg(REG_RADIUS_A, a);
    put_reg(REG_RADIUS_B, b);
    put_reg(REG_ANGLE_STEP, st);
    put_reg(REG_FACTOR_SET, fac);
    put_reg(REG_CENTER_X, x);
    put_reg(REG_CENTER_Y, y);
    put_reg(REG_PALETTE_SIZE, pl);
    cfg_we <= 1'b0;
  endtask

  // one request transaction, then a random gap
  task automatic send_req(bit start_req);
    int gap;
    in_valid <= 1'b1;
    in_start_req <= start_req;
    do @(posedge clk); while (in_stall);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every segment is in and the block is idle
  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (sb.pending() != 0 || in_stall) @(posedge clk);
    repeat (START_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned fig_len;
    int unsigned cut;
    logic [2:0] idx;

    sb = new();
    cycles = 0;
    calm = 1'b0;
    step_now = 1;
    counted = 0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_start_req = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: segment request before any figure gives nothing
    send_req(1'b0);

    // zero step, all multipliers negative, small palette, idle request after last
    settle();
    put_all(12'h7FF, 12'h801, 12'h000, 12'h924, 12'h7FF, 12'h000, 12'h003);
    send_req(1'b1);
    repeat (4) send_req(1'b0);
    send_req(1'b0);

    // step beyond the table, all multipliers -1, full palette, restart mid-figure
    settle();
    put_reg(REG_NONE, 12'hFFF);
    put_all(12'h800, 12'h7FF, 12'hFFF, 12'hFFF, 12'h800, 12'h7FF, 12'hFFF);
    send_req(1'b1);
    repeat (3) send_req(1'b0);
    send_req(1'b1);
    repeat (2) send_req(1'b0);

    // half-turn step, zero multipliers, palette at the mono boundary
    settle();
    put_all(12'h400, 12'hC00, 12'd180, 12'h000, 12'd1024, 12'd1024, 12'h002);
    send_req(1'b1);
    repeat (6) send_req(1'b0);

    // random figures
    while (counted < ITEM_TARGET) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) != 0) begin
        settle();
        for (int r = 0; r < 7; r++) begin
          put_reg(3'(r), reg_value(3'(r)));
        end
        if ($urandom_range(0, 3) == 0) put_reg(REG_NONE, reg_value(REG_NONE));
        cfg_we <= 1'b0;
      end
      fig_len = 2 * (1 + ANGLE_STEPS / steps_gcd(step_now));
      cut = fig_len;
      if (fig_len > 80 && $urandom_range(0, 3) != 0) cut = $urandom_range(1, 40);
      else if ($urandom_range(0, 3) == 0) cut = $urandom_range(1, fig_len);
      send_req(1'b1);
      counted++;
      for (int i = 0; i < cut; i++) begin
        // registers rewritten while a figure runs
        if ($urandom_range(0, 30) == 0) begin
          settle();
          idx = 3'($urandom_range(0, 7));
          put_reg(idx, reg_value(idx));
          cfg_we <= 1'b0;
        end
        send_req(1'b0);
        counted++;
      end
      if (cut == fig_len) repeat ($urandom_range(0, 2)) send_req(1'b0);
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
design/salg_pkg.sv
design/salg_div.sv
design/salg_coord.sv
design/string_art_line_generator_core.sv
verif/tb_string_art_line_generator_core.sv
